// File: rtl/mdnr_pkg.sv
// Shared constants, state encoding and control structures for the mono downmix resampler.
package mdnr_pkg;

  // Field and register widths
  localparam int SAMPLE_W    = 16;
  localparam int CHAN_CNT_W  = 4;
  localparam int CHAN_IDX_W  = 3;
  localparam int STEP_W      = 12;
  localparam int SUM_W       = 20;
  localparam int MAG_W       = SUM_W - 1;
  localparam int PHASE_W     = 14;
  localparam int POS_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int DIV_CNT_W   = 5;
  localparam int RES_CNT_W   = 7;

  // Behavioural constants
  localparam int MAX_CHANNELS = 8;
  localparam int PHASE_ONE    = 256;
  localparam int MAX_RESULTS  = 64;
  localparam int MIN_STEP     = 4;

  localparam logic signed [POS_W-1:0]   POS_LIMIT   = POS_W'(PHASE_ONE - 1);
  localparam logic signed [PHASE_W-1:0] PHASE_RESET = PHASE_W'(-PHASE_ONE);
  localparam logic signed [PHASE_W-1:0] PHASE_WRAP  = PHASE_W'(PHASE_ONE);
  localparam logic [DIV_CNT_W-1:0]      DIV_LAST_BIT = DIV_CNT_W'(MAG_W - 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP     = 2'd1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic div_step;
    logic advance;
    logic load_out;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic frame_done;
    logic div_last;
    logic fits;
    logic cap_full;
    logic slot_free;
  } status_t;

endpackage

// File: rtl/mdnr_ctrl.sv
// Controller state machine: frame accumulation, divide sequencing and output run.
module mdnr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  mdnr_pkg::status_t status,
  output mdnr_pkg::cmd_t    cmd
);
  import mdnr_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = in_valid;
        if (in_valid && status.frame_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!status.fits) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else if (status.cap_full) begin
          // Positions beyond the result limit are stepped over silently.
          cmd.advance = 1'b1;
        end else if (status.slot_free) begin
          cmd.advance  = 1'b1;
          cmd.load_out = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Input items are taken only while idle.
  assign in_stall = (state != ST_IDLE);

endmodule

// File: rtl/mdnr_datapath.sv
// Datapath: configuration, channel summing, serial divider, phase stepping and output register.
module mdnr_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [mdnr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mdnr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [mdnr_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [mdnr_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 last_of_run,
  input  mdnr_pkg::cmd_t                       cmd,
  output mdnr_pkg::status_t                    status
);
  import mdnr_pkg::*;

  logic [CHAN_CNT_W-1:0]       channel_count;
  logic [STEP_W-1:0]           rate_step;
  logic signed [SUM_W-1:0]     channel_sum;
  logic [CHAN_IDX_W-1:0]       channel_index;
  logic [CHAN_CNT_W-1:0]       div_rem;
  logic [MAG_W-1:0]            div_quo;
  logic [DIV_CNT_W-1:0]        div_cnt;
  logic                        div_neg;
  logic signed [PHASE_W-1:0]   phase;
  logic signed [PHASE_W-1:0]   pos;
  logic [RES_CNT_W-1:0]        emitted;
  logic                        first_pending;

  logic [CHAN_CNT_W-1:0]       eff_chans;
  logic [STEP_W-1:0]           eff_step;
  logic signed [SUM_W-1:0]     sum_new;
  logic [SUM_W-1:0]            sum_mag;
  logic [CHAN_CNT_W:0]         trial;
  logic                        trial_ge;
  logic signed [SAMPLE_W-1:0]  mono;
  logic signed [POS_W-1:0]     step_ext;
  logic signed [POS_W-1:0]     nxt;
  logic signed [POS_W-1:0]     nxt2;
  logic                        last_flag;

  // Effective register values with out-of-range codes clamped
  always_comb begin
    if (channel_count == '0) begin
      eff_chans = CHAN_CNT_W'(1);
    end else if (channel_count > CHAN_CNT_W'(MAX_CHANNELS)) begin
      eff_chans = CHAN_CNT_W'(MAX_CHANNELS);
    end else begin
      eff_chans = channel_count;
    end
    if (rate_step < STEP_W'(MIN_STEP)) begin
      eff_step = STEP_W'(MIN_STEP);
    end else begin
      eff_step = rate_step;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHAN_CNT_W'(1);
      rate_step     <= STEP_W'(PHASE_ONE);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CHAN_CNT_W-1:0];
        CFG_RATE_STEP:     rate_step     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame sum and its magnitude for the divider
  assign sum_new = channel_sum + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
  assign sum_mag = sum_new[SUM_W-1] ? (SUM_W'(0) - sum_new) : sum_new;
  assign status.frame_done = ({1'b0, channel_index} + CHAN_CNT_W'(1)) >= eff_chans;

  // Restoring divider step: one quotient bit per cycle
  assign trial    = {div_rem, div_quo[MAG_W-1]};
  assign trial_ge = trial >= {1'b0, eff_chans};
  assign status.div_last = (div_cnt == '0);

  // Quotient with the sign restored, truncated toward zero
  assign mono = div_neg ? SAMPLE_W'(SAMPLE_W'(0) - div_quo[SAMPLE_W-1:0])
                        : div_quo[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_sum   <= '0;
      channel_index <= '0;
    end else if (cmd.take) begin
      if (status.frame_done) begin
        channel_sum   <= '0;
        channel_index <= '0;
      end else begin
        channel_sum   <= sum_new;
        channel_index <= channel_index + CHAN_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.frame_done) begin
      div_quo <= sum_mag[MAG_W-1:0];
      div_rem <= '0;
      div_cnt <= DIV_LAST_BIT;
      div_neg <= sum_new[SUM_W-1];
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[MAG_W-2:0], trial_ge};
      div_rem <= trial_ge ? CHAN_CNT_W'(trial - {1'b0, eff_chans})
                          : trial[CHAN_CNT_W-1:0];
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // Output position stepping
  assign step_ext  = {{(POS_W-STEP_W){1'b0}}, eff_step};
  assign nxt       = {{(POS_W-PHASE_W){pos[PHASE_W-1]}}, pos} + step_ext;
  assign nxt2      = nxt + step_ext;
  assign last_flag = (emitted == RES_CNT_W'(MAX_RESULTS - 1)) || (nxt2 > POS_LIMIT);

  assign status.fits      = (nxt <= POS_LIMIT);
  assign status.cap_full  = (emitted == RES_CNT_W'(MAX_RESULTS));
  assign status.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PHASE_RESET;
      first_pending <= 1'b1;
    end else if (cmd.finish) begin
      phase         <= pos - PHASE_WRAP;
      first_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && status.frame_done) begin
      pos     <= phase;
      emitted <= '0;
    end else if (cmd.advance) begin
      pos <= nxt[PHASE_W-1:0];
      if (cmd.load_out) begin
        emitted <= emitted + RES_CNT_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_sample  <= (first_pending && nxt[POS_W-1]) ? '0 : mono;
      last_of_run <= last_flag;
    end
  end

endmodule

// File: rtl/mono_downmix_nearest_resampler.sv
// Top level of the mono downmix and nearest-sample resampler.
// Samples that do not complete a frame are taken one per cycle.
// A frame's last sample starts a serial divide; results then leave
// at one per cycle while the output is not stalled.
// A completing sample keeps the input stalled through the divide, one step for each
// output position in the frame (results plus positions stepped over past 64) and the
// return to idle; output stalls during the run lengthen this.
// Synchronous reset restores the default registers, clears the frame and empties the output.
module mono_downmix_nearest_resampler (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mdnr_pkg::SAMPLE_W-1:0] sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mdnr_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                 last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mdnr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mdnr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mdnr_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  // Controller
  mdnr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  mdnr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_sample  (out_sample),
    .last_of_run (last_of_run),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// File: rtl/mdnr_checker.sv
// Port-level checks for the resampler, bound to the top level.
module mdnr_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_stall,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [mdnr_pkg::SAMPLE_W-1:0] out_sample,
  input  logic                                 last_of_run
);
  import mdnr_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(last_of_run))
    else $error("stalled result item changed");

  // New results appear only while a frame is being worked on.
  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result item appeared while the block was idle");

  // After a non-final result is taken, the run is still in progress.
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> in_stall)
    else $error("block went idle before the final item of a run");

  // Reset leaves the block idle with no result pending.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind mono_downmix_nearest_resampler mdnr_checker u_mdnr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_sample  (out_sample),
  .last_of_run (last_of_run)
);

// File: tb/sv/mono_downmix_nearest_resampler_tb.sv
// Self-checking testbench for the mono downmix and nearest-sample resampler.
`timescale 1ns / 1ps

module mono_downmix_nearest_resampler_tb;
  import mdnr_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 100;
  // Index past the defined registers; the block ignores writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] mono;
    logic                       run_end;
  } mono_out_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       last_of_run;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Predictor state, mirroring the block's registers.
  logic [CHAN_CNT_W-1:0]      chan_setting;
  logic [STEP_W-1:0]          step_setting;
  logic signed [SUM_W-1:0]    mix_sum;
  logic [CHAN_IDX_W-1:0]      mix_count;
  logic signed [PHASE_W-1:0]  out_phase;
  logic                       awaiting_first;
  int                         frame_positions;

  mono_out_t expected_mono_q[$];
  int        error_count = 0;
  int        out_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;

  mono_downmix_nearest_resampler u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_sample  (out_sample),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Abandon the run if it has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Accumulate one channel sample; on a completed frame, queue every output it gives.
  function automatic void predict_resampled_outputs(input logic signed [SAMPLE_W-1:0] s);
    int        chans;
    int        stepv;
    int        idx_next;
    int        mono;
    int        span;
    int        count;
    int        emit;
    int        pos;
    mono_out_t res;
    chans = (chan_setting == 0) ? 1 :
            (chan_setting > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_setting);
    stepv = (step_setting < MIN_STEP) ? MIN_STEP : int'(step_setting);
    mix_sum = mix_sum + s;
    idx_next = int'(mix_count) + 1;
    if (idx_next < chans) begin
      mix_count = idx_next[CHAN_IDX_W-1:0];
      return;
    end
    mono = int'(mix_sum) / chans;
    mix_sum = '0;
    mix_count = '0;
    // Output positions still short of the end of this mono sample.
    span = PHASE_ONE - 1 - int'(out_phase);
    count = (span >= 0) ? span / stepv : 0;
    emit = (count > MAX_RESULTS) ? MAX_RESULTS : count;
    pos = int'(out_phase);
    for (int k = 0; k < emit; k++) begin
      pos += stepv;
      res.mono = (awaiting_first && pos < 0) ? '0 : SAMPLE_W'(mono);
      res.run_end = (k == emit - 1);
      expected_mono_q.push_back(res);
    end
    out_phase = PHASE_W'(int'(out_phase) + count * stepv - PHASE_ONE);
    awaiting_first = 1'b0;
    frame_positions = count;
  endfunction

  // Compare each accepted output item with the oldest expectation; stall at random.
  always @(posedge clk) begin : check_outputs
    mono_out_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_mono_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("output item %0d arrived with none expected: sample %0d last %0b",
                   out_count, out_sample, last_of_run);
      end else begin
        want = expected_mono_q.pop_front();
        if (out_sample !== want.mono || last_of_run !== want.run_end) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("output item %0d: expected sample %0d last %0b, got sample %0d last %0b",
                     out_count, want.mono, want.run_end, out_sample, last_of_run);
        end
      end
      out_count++;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one channel sample, after a random idle gap, and wait for it to be taken.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 8) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_resampled_outputs(value);
  endtask

  // Stop sending, collect every expected output, then let the block finish stepping.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_mono_q.size() != 0) @(posedge clk);
    repeat (frame_positions + 40) @(posedge clk);
  endtask

  // Write one register; the channel is left valid for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_CHANNEL_COUNT) chan_setting = val[CHAN_CNT_W-1:0];
    else if (idx == CFG_RATE_STEP) step_setting = val[STEP_W-1:0];
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] chans, input logic [CFG_DATA_W-1:0] stepv);
    write_reg(CFG_CHANNEL_COUNT, chans);
    write_reg(CFG_RATE_STEP, stepv);
    cfg_valid <= 1'b0;
  endtask

  // Zero channel count and a step below the minimum, straight after reset:
  // the first frame gives zeros before the first sample and hits the output cap.
  task automatic test_first_frame_and_limits();
    configure(12'hFF0, 12'd3);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    wait_idle();
  endtask

  // Full-scale and alternating bit patterns at one output per sample.
  task automatic test_sample_extremes();
    write_reg(CFG_UNUSED, 12'hFFF);
    configure(12'd1, 12'd256);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'shFFFF);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    wait_idle();
  endtask

  // Channel count above the maximum, the largest step, and division truncating toward zero.
  task automatic test_downmix_truncation();
    configure(12'd15, 12'd4095);
    repeat (8) send_sample(16'sh8000);
    wait_idle();
    configure(12'd3, 12'd200);
    send_sample(-16'sd1);
    send_sample(-16'sd1);
    send_sample(-16'sd3);
    wait_idle();
  endtask

  // Lowering the channel count mid-frame completes the frame on the next sample.
  task automatic test_count_lowered_mid_frame();
    configure(12'd8, 12'd256);
    send_sample(16'sd1000);
    send_sample(-16'sd7);
    send_sample(16'sd32767);
    send_sample(16'sd5);
    send_sample(-16'sd32768);
    wait_idle();
    configure(12'd2, 12'd300);
    send_sample(16'sd12345);
    wait_idle();
  endtask

  // Random samples and settings under one idling pattern.
  task automatic test_random_traffic(input int idle_pct, input int stall_level);
    logic [CFG_DATA_W-1:0]      chans;
    logic [CFG_DATA_W-1:0]      stepv;
    logic signed [SAMPLE_W-1:0] value;
    send_idle_pct = idle_pct;
    stall_pct = stall_level;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // New settings at the start and now and then, often in the middle of a frame.
      if (n == 0 || $urandom_range(99) < 5) begin
        wait_idle();
        chans = ($urandom_range(99) < 30) ? CFG_DATA_W'($urandom_range(15))
                                          : CFG_DATA_W'($urandom_range(1, 3));
        case ($urandom_range(9))
          0: stepv = CFG_DATA_W'($urandom_range(0, MIN_STEP - 1));
          1: stepv = 12'd4095;
          2: stepv = CFG_DATA_W'($urandom_range(MIN_STEP, 32));
          default: stepv = CFG_DATA_W'($urandom_range(64, 1024));
        endcase
        if ($urandom_range(1)) chans[CFG_DATA_W-1:CHAN_CNT_W] = (CFG_DATA_W-CHAN_CNT_W)'($urandom);
        configure(chans, stepv);
      end
      case ($urandom_range(19))
        0: value = 16'sh7FFF;
        1: value = 16'sh8000;
        2: value = 16'sh0000;
        default: value = SAMPLE_W'($urandom);
      endcase
      send_sample(value);
    end
  endtask

  initial begin
    chan_setting = 4'd1;
    step_setting = 12'd256;
    mix_sum = '0;
    mix_count = '0;
    out_phase = PHASE_RESET;
    awaiting_first = 1'b1;
    frame_positions = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_first_frame_and_limits();
    test_sample_extremes();
    test_downmix_truncation();
    test_count_lowered_mid_frame();
    test_random_traffic(0, 0);
    test_random_traffic(48, 0);
    test_random_traffic(0, 48);
    test_random_traffic(18, 18);
    wait_idle();

    if (expected_mono_q.size() != 0) begin
      $display("%0d expected output items never arrived", expected_mono_q.size());
      error_count += expected_mono_q.size();
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: mono_downmix_nearest_resampler.f
rtl/mdnr_pkg.sv
rtl/mdnr_ctrl.sv
rtl/mdnr_datapath.sv
rtl/mono_downmix_nearest_resampler.sv
rtl/mdnr_checker.sv
tb/sv/mono_downmix_nearest_resampler_tb.sv
